FILE: hw/rtl/sler_pkg.sv
// ---------------------------------------------------------------------------
// sler_pkg: shared types and constants for the servo ease ramp
// Widths of the bit-serial units, request structs, pulse limits, codes.
// ---------------------------------------------------------------------------
`default_nettype none

package sler_pkg;

  // Pulse and register widths
  localparam int PULSE_BITS = 12;
  localparam int EASE_W     = 16;
  localparam int ADDR_W     = 2;
  localparam int CFG_W      = 16;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 16;

  // Bit-serial multiplier: A operand x B operand, one B bit per cycle
  localparam int MUL_A_W = 28;
  localparam int MUL_B_W = PULSE_BITS;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Degree handling and reset values
  localparam logic [PULSE_BITS-1:0] DEG_LIMIT = PULSE_BITS'(200);
  localparam logic [MUL_A_W-1:0]    DEG_SPAN  = MUL_A_W'(180);
  localparam logic [PULSE_BITS-1:0] MID_PULSE = PULSE_BITS'(1500);
  localparam logic [PULSE_BITS-1:0] PULSE_TOP = {PULSE_BITS{1'b1}};

  localparam logic [PULSE_BITS-1:0] RST_PULSE_MIN = PULSE_BITS'(544);
  localparam logic [PULSE_BITS-1:0] RST_PULSE_MAX = PULSE_BITS'(2400);
  localparam logic [EASE_W-1:0]     RST_EASE_TIME = EASE_W'(1000);
  localparam logic [PULSE_BITS-1:0] RST_FULL_SPAN = PULSE_BITS'(1856);

  // Register indexes
  localparam logic [ADDR_W-1:0] REG_PULSE_MIN = 2'd0;
  localparam logic [ADDR_W-1:0] REG_PULSE_MAX = 2'd1;
  localparam logic [ADDR_W-1:0] REG_EASE_TIME = 2'd2;
  localparam logic [ADDR_W-1:0] REG_FULL_SPAN = 2'd3;

  // Input item kinds
  localparam logic OP_MOVE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic [PROD_W-1:0]  dividend;
    logic [MUL_A_W-1:0] divisor;
  } div_req_t;

  // Saturate a signed intermediate to the pulse range
  function automatic logic [PULSE_BITS-1:0] clamp_pulse(input logic signed [PULSE_BITS+2:0] v);
    logic [PULSE_BITS-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({3'b000, PULSE_TOP})) begin
      r = PULSE_TOP;
    end else begin
      r = v[PULSE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sler_mul.sv
// ---------------------------------------------------------------------------
// sler_mul: bit-serial shift-add multiplier
// One bit of the B operand per cycle; done marks the product ready in p.
// ---------------------------------------------------------------------------
`default_nettype none

module sler_mul (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire sler_pkg::mul_req_t         req,
  output logic                            done,
  output logic [sler_pkg::PROD_W-1:0]     p
);

  localparam int CNT_W = $clog2(sler_pkg::MUL_B_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(sler_pkg::MUL_B_W - 1);

  logic                        busy;
  logic [CNT_W-1:0]            cnt;
  logic [sler_pkg::MUL_A_W-1:0] a;
  logic [sler_pkg::MUL_A_W:0]   sum;

  // Add A into the high half when the low bit of the shifting B is set
  always_comb begin
    sum = {1'b0, p[sler_pkg::PROD_W-1:sler_pkg::MUL_B_W]}
          + (p[0] ? {1'b0, a} : '0);
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: product register shifts right one bit per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      a <= req.a;
      p <= {{sler_pkg::MUL_A_W{1'b0}}, req.b};
    end else if (busy) begin
      p <= {sum, p[sler_pkg::MUL_B_W-1:1]};
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sler_div.sv
// ---------------------------------------------------------------------------
// sler_div: bit-serial restoring divider
// One quotient bit per cycle; done marks the quotient ready in q.
// ---------------------------------------------------------------------------
`default_nettype none

module sler_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire sler_pkg::div_req_t         req,
  output logic                            done,
  output logic [sler_pkg::PROD_W-1:0]     q
);

  localparam int CNT_W = $clog2(sler_pkg::PROD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(sler_pkg::PROD_W - 1);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic [sler_pkg::MUL_A_W-1:0]  dvs;
  logic [sler_pkg::MUL_A_W-1:0]  rem;
  logic [sler_pkg::MUL_A_W:0]    sh;
  logic [sler_pkg::MUL_A_W+1:0]  diff;
  logic                          qbit;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    sh   = {rem, q[sler_pkg::PROD_W-1]};
    diff = {1'b0, sh} - {2'b00, dvs};
    qbit = ~diff[sler_pkg::MUL_A_W+1];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out the top of q, quotient bits in the bottom
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvs <= req.divisor;
      rem <= '0;
      q   <= req.dividend;
    end else if (busy) begin
      rem <= qbit ? diff[sler_pkg::MUL_A_W-1:0] : sh[sler_pkg::MUL_A_W-1:0];
      q   <= {q[sler_pkg::PROD_W-2:0], qbit};
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/servo_linear_ease_ramp_top.sv
// ---------------------------------------------------------------------------
// servo_linear_ease_ramp_top: servo pulse ramp with linear easing
// Move commands set a goal (degrees or microseconds) and plan a ramp;
// millisecond ticks step the pulse width along the ramp.
//
//   channel   dir  fields (low bit up)                       handshake
//   s_*       in   tdata: target_value[11:0]; tuser: opcode  tvalid/tready
//   m_*       out  tdata: pulse_width[11:0], moving, done    tvalid/tready
//   cfg_*     in   addr: register index, wdata: value        cfg_we only
//
// One item at a time. A ramp tick runs a serial multiply then a serial
// divide. A move in microseconds runs the same pair; a move in degrees
// runs the pair first to convert the angle, then to plan the ramp. An idle
// tick or a move that plans nothing beyond the compare uses neither unit.
// Reset is synchronous; the block takes a new item while a result waits
// on the output register, and holds its result until m_tready.
// ---------------------------------------------------------------------------
`default_nettype none

module servo_linear_ease_ramp_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Input stream
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [sler_pkg::S_TDATA_W-1:0]   s_tdata,  // target_value[11:0], zero pad
  input  wire logic                             s_tuser,  // opcode
  // Output stream
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [sler_pkg::M_TDATA_W-1:0]        m_tdata,  // pulse_width[11:0], moving, ramp_done, pad
  // Configuration
  input  wire logic                             cfg_we,
  input  wire logic [sler_pkg::ADDR_W-1:0]      cfg_addr,
  input  wire logic [sler_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int PW = sler_pkg::PULSE_BITS;
  localparam int AW = sler_pkg::MUL_A_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DEG_MUL, ST_DEG_DIV, ST_DIST, ST_DIST_MUL, ST_DIST_DIV,
    ST_TICK_MUL, ST_TICK_DIV, ST_EMIT
  } state_t;

  state_t state;

  // Configuration registers
  logic [PW-1:0]               pulse_min;
  logic [PW-1:0]               pulse_max;
  logic [sler_pkg::EASE_W-1:0] ease_time;
  logic [PW-1:0]               full_span;

  // Ramp state
  logic [PW-1:0] current_pulse;
  logic [PW-1:0] start_pulse;
  logic [PW-1:0] goal_pulse;
  logic [AW-1:0] step_index;
  logic [AW-1:0] step_total;
  logic          ramp_active;
  logic          ramp_done;

  // Working registers
  logic [PW-1:0] goal;
  logic          neg;

  sler_pkg::mul_req_t           mul_req;
  sler_pkg::div_req_t           div_req;
  logic                         mul_done;
  logic                         div_done;
  logic [sler_pkg::PROD_W-1:0]  mul_p;
  logic [sler_pkg::PROD_W-1:0]  div_q;

  sler_mul u_mul (.clk(clk), .rst(rst), .req(mul_req), .done(mul_done), .p(mul_p));
  sler_div u_div (.clk(clk), .rst(rst), .req(div_req), .done(div_done), .q(div_q));

  // Signed differences and their magnitudes
  logic [PW:0]   span, delta, gdiff;
  logic [PW-1:0] span_mag, delta_mag, gdiff_mag;
  logic [AW:0]   index_inc;
  logic signed [PW+2:0] deg_scaled, deg_val, tick_val;

  always_comb begin
    span      = {1'b0, pulse_max} - {1'b0, pulse_min};
    span_mag  = span[PW] ? PW'(-span) : span[PW-1:0];
    delta     = {1'b0, goal_pulse} - {1'b0, start_pulse};
    delta_mag = delta[PW] ? PW'(-delta) : delta[PW-1:0];
    gdiff     = {1'b0, goal} - {1'b0, current_pulse};
    gdiff_mag = gdiff[PW] ? PW'(-gdiff) : gdiff[PW-1:0];
    index_inc = {1'b0, step_index} + 1'b1;
    // Degree result: quotient below 2^(PW+1), sign applied, offset by min
    deg_scaled = neg ? -$signed({2'b00, div_q[PW:0]}) : $signed({2'b00, div_q[PW:0]});
    deg_val    = deg_scaled + $signed({3'b000, pulse_min});
    // Tick result: quotient below the ramp distance
    tick_val   = neg ? $signed({3'b000, start_pulse}) - $signed({3'b000, div_q[PW-1:0]})
                     : $signed({3'b000, start_pulse}) + $signed({3'b000, div_q[PW-1:0]});
  end

  assign s_tready = (state == ST_IDLE);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_min <= sler_pkg::RST_PULSE_MIN;
      pulse_max <= sler_pkg::RST_PULSE_MAX;
      ease_time <= sler_pkg::RST_EASE_TIME;
      full_span <= sler_pkg::RST_FULL_SPAN;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        sler_pkg::REG_PULSE_MIN: pulse_min <= cfg_wdata[PW-1:0];
        sler_pkg::REG_PULSE_MAX: pulse_max <= cfg_wdata[PW-1:0];
        sler_pkg::REG_EASE_TIME: ease_time <= cfg_wdata;
        sler_pkg::REG_FULL_SPAN: full_span <= cfg_wdata[PW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: state, ramp state, unit requests and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      current_pulse <= sler_pkg::MID_PULSE;
      start_pulse   <= '0;
      goal_pulse    <= '0;
      step_index    <= '0;
      step_total    <= '0;
      ramp_active   <= 1'b0;
      ramp_done     <= 1'b0;
      goal          <= '0;
      neg           <= 1'b0;
      mul_req       <= '0;
      div_req       <= '0;
      m_tvalid      <= 1'b0;
      m_tdata       <= '0;
    end else begin
      // Output register empties on a handshake unless reloaded below
      if (m_tvalid && m_tready && (state != ST_EMIT)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            ramp_done <= 1'b0;
            if (s_tuser == sler_pkg::OP_MOVE) begin
              ramp_active <= 1'b0;
              step_index  <= '0;
              step_total  <= '0;
              if (s_tdata[PW-1:0] < sler_pkg::DEG_LIMIT) begin
                mul_req <= '{start: 1'b1, a: AW'(s_tdata[PW-1:0]), b: span_mag};
                neg     <= span[PW];
                state   <= ST_DEG_MUL;
              end else begin
                goal  <= s_tdata[PW-1:0];
                state <= ST_DIST;
              end
            end else if (ramp_active) begin
              mul_req <= '{start: 1'b1, a: step_index, b: delta_mag};
              neg     <= delta[PW];
              state   <= ST_TICK_MUL;
            end else begin
              state <= ST_EMIT;
            end
          end
        end

        // Start strobes last one cycle: cleared in the wait states
        ST_DEG_MUL: begin
          mul_req.start <= 1'b0;
          if (mul_done) begin
            div_req <= '{start: 1'b1, dividend: mul_p, divisor: sler_pkg::DEG_SPAN};
            state   <= ST_DEG_DIV;
          end
        end

        ST_DEG_DIV: begin
          div_req.start <= 1'b0;
          if (div_done) begin
            goal  <= sler_pkg::clamp_pulse(deg_val);
            state <= ST_DIST;
          end
        end

        // Plan the ramp length: ease_time * distance / full_span
        ST_DIST: begin
          if ((goal == current_pulse) || (full_span == '0)) begin
            state <= ST_EMIT;
          end else begin
            mul_req <= '{start: 1'b1, a: AW'(ease_time), b: gdiff_mag};
            state   <= ST_DIST_MUL;
          end
        end

        ST_DIST_MUL: begin
          mul_req.start <= 1'b0;
          if (mul_done) begin
            div_req <= '{start: 1'b1, dividend: mul_p, divisor: AW'(full_span)};
            state   <= ST_DIST_DIV;
          end
        end

        ST_DIST_DIV: begin
          div_req.start <= 1'b0;
          if (div_done) begin
            if (div_q[AW-1:0] != '0) begin
              start_pulse <= current_pulse;
              goal_pulse  <= goal;
              step_total  <= div_q[AW-1:0];
              ramp_active <= 1'b1;
            end
            state <= ST_EMIT;
          end
        end

        // One ramp step: start + index * delta / total
        ST_TICK_MUL: begin
          mul_req.start <= 1'b0;
          if (mul_done) begin
            div_req <= '{start: 1'b1, dividend: mul_p, divisor: step_total};
            state   <= ST_TICK_DIV;
          end
        end

        ST_TICK_DIV: begin
          div_req.start <= 1'b0;
          if (div_done) begin
            current_pulse <= sler_pkg::clamp_pulse(tick_val);
            step_index    <= index_inc[AW-1:0];
            if (index_inc >= {1'b0, step_total}) begin
              ramp_active <= 1'b0;
              ramp_done   <= 1'b1;
            end
            state <= ST_EMIT;
          end
        end

        // Load the output register once it is free
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= sler_pkg::M_TDATA_W'({ramp_done, ramp_active, current_pulse});
            state    <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // A running ramp always has a length and has not passed its end
  a_ramp_len: assert property (@(posedge clk) disable iff (rst)
    ramp_active |-> (step_total != '0))
    else $error("ramp active with zero length");

  a_ramp_idx: assert property (@(posedge clk) disable iff (rst)
    ramp_active |-> (step_index < step_total))
    else $error("ramp index past its length");

  // The final step ends the ramp
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[PW+1]) |-> !m_tdata[PW])
    else $error("ramp_done reported while still moving");

  // Multiplier results are only taken up by a multiply wait state
  a_mul_owner: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_DEG_MUL || state == ST_DIST_MUL || state == ST_TICK_MUL))
    else $error("multiplier finished outside a multiply step");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the servo linear ease ramp
// Drives move and tick items through the input stream, predicts each
// result from a behavioural copy of the ramp planner and compares every
// output item field by field. A short directed table comes first, then
// random phases under varied calibration, including extreme settings.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 92;
  localparam int DRAIN_CYCLES = 200;
  localparam int PW           = sler_pkg::PULSE_BITS;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  // Output item layout, low bit up: width, moving, ramp_done
  typedef struct packed {
    logic          ramp_done;
    logic          moving;
    logic [PW-1:0] width;
  } pulse_report_t;

  typedef struct {
    row_kind_t                   kind;
    logic [sler_pkg::ADDR_W-1:0] addr;
    logic                        op;
    int                          value;
    bit                          typed;
    pulse_report_t               want;
  } plan_row_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [sler_pkg::S_TDATA_W-1:0] s_tdata = '0;   // target_value[11:0], zero pad
  logic                           s_tuser = 1'b0; // opcode
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [sler_pkg::M_TDATA_W-1:0] m_tdata;        // pulse_width[11:0], moving, ramp_done, pad
  logic                           cfg_we = 1'b0;
  logic [sler_pkg::ADDR_W-1:0]    cfg_addr = '0;
  logic [sler_pkg::CFG_W-1:0]     cfg_wdata = '0;

  servo_linear_ease_ramp_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Calibration as the bench believes it to be
  logic [PW-1:0]               lim_lo;
  logic [PW-1:0]               lim_hi;
  logic [sler_pkg::EASE_W-1:0] ease_ms;
  logic [PW-1:0]               span_us;

  // Ramp state
  int     pw_now;
  int     ramp_from;
  int     ramp_to;
  longint step_no;
  longint step_cnt;
  bit     ramp_on;

  pulse_report_t expected_reports[$];
  plan_row_t     plan[$];
  int            errors = 0;
  int            cycle_count = 0;
  bit            tx_steady = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int sat_pulse(longint v);
    if (v < 0) return 0;
    if (v > longint'(sler_pkg::PULSE_TOP)) return int'(sler_pkg::PULSE_TOP);
    return int'(v);
  endfunction

  // Advance the ramp planner by one input item and report the output item
  function automatic pulse_report_t step_ramp(logic op, logic [PW-1:0] target);
    pulse_report_t r;
    int            goal;
    int            span;
    longint        travel;
    longint        d;
    longint        delta;
    bit            done;
    done = 1'b0;
    if (op == sler_pkg::OP_MOVE) begin
      if (target < sler_pkg::DEG_LIMIT) begin
        // degrees: signed scale so a reversed calibration clamps at zero
        span = int'(lim_hi) - int'(lim_lo);
        goal = sat_pulse(longint'(int'(target) * span / int'(sler_pkg::DEG_SPAN)
                                  + int'(lim_lo)));
      end else begin
        goal = int'(target);
      end
      ramp_on  = 1'b0;
      step_no  = 0;
      step_cnt = 0;
      if (goal != pw_now) begin
        travel = (goal > pw_now) ? goal - pw_now : pw_now - goal;
        d      = (span_us == 0) ? 0 : longint'(ease_ms) * travel / longint'(span_us);
        if (d != 0) begin
          ramp_from = pw_now;
          ramp_to   = goal;
          step_cnt  = d;
          ramp_on   = 1'b1;
        end
      end
    end else if (ramp_on) begin
      delta  = longint'(ramp_to) - longint'(ramp_from);
      pw_now = sat_pulse(step_no * delta / step_cnt + longint'(ramp_from));
      step_no++;
      if (step_no >= step_cnt) begin
        ramp_on = 1'b0;
        done    = 1'b1;
      end
    end
    r.width     = pw_now[PW-1:0];
    r.moving    = ramp_on;
    r.ramp_done = done;
    return r;
  endfunction

  function automatic void add_item(logic op, int value, bit typed = 1'b0, int w = 0,
                                   bit mv = 1'b0, bit dn = 1'b0);
    plan_row_t r;
    r.kind           = ROW_ITEM;
    r.addr           = '0;
    r.op             = op;
    r.value          = value;
    r.typed          = typed;
    r.want.width     = w[PW-1:0];
    r.want.moving    = mv;
    r.want.ramp_done = dn;
    plan.push_back(r);
  endfunction

  function automatic void add_reg(logic [sler_pkg::ADDR_W-1:0] addr, int value);
    plan_row_t r;
    r.kind  = ROW_REG;
    r.addr  = addr;
    r.op    = sler_pkg::OP_TICK;
    r.value = value;
    r.typed = 1'b0;
    r.want  = '0;
    plan.push_back(r);
  endfunction

  // Register write; cfg_we drops again before the task returns, so each call makes one update
  task automatic write_reg(logic [sler_pkg::ADDR_W-1:0] idx, int value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value[sler_pkg::CFG_W-1:0];
    @(posedge clk);
    case (idx)
      sler_pkg::REG_PULSE_MIN: lim_lo  = value[PW-1:0];
      sler_pkg::REG_PULSE_MAX: lim_hi  = value[PW-1:0];
      sler_pkg::REG_EASE_TIME: ease_ms = value[sler_pkg::EASE_W-1:0];
      sler_pkg::REG_FULL_SPAN: span_us = value[PW-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Hold input and let every pending output item drain
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_item(logic op, logic [PW-1:0] target, bit typed,
                           pulse_report_t want);
    pulse_report_t pred;
    int            gap;
    gap = tx_steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= sler_pkg::S_TDATA_W'(target);
    do @(posedge clk); while (s_tready !== 1'b1);
    pred = step_ramp(op, target);
    expected_reports.push_back(typed ? want : pred);
  endtask

  // Mostly ticks while a ramp runs so ramps get to finish
  task automatic random_item();
    logic          op;
    logic [PW-1:0] tgt;
    int            pick;
    if (ramp_on) op = ($urandom_range(0, 9) < 8) ? sler_pkg::OP_TICK : sler_pkg::OP_MOVE;
    else op = ($urandom_range(0, 1) == 0) ? sler_pkg::OP_TICK : sler_pkg::OP_MOVE;
    tgt = PW'($urandom_range(0, 4095));
    if (op == sler_pkg::OP_MOVE) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2, 3: tgt = PW'($urandom_range(0, 199));
        4: tgt = $urandom_range(0, 1) ? PW'(199) : PW'(0);
        5: tgt = $urandom_range(0, 1) ? sler_pkg::PULSE_TOP : sler_pkg::DEG_LIMIT;
        6: tgt = pw_now[PW-1:0];  // same as now: nothing moves, unless it is below DEG_LIMIT and so read as degrees
        default: ;
      endcase
    end
    send_item(op, tgt, 1'b0, '0);
  endtask

  // Calibration per phase; the first few are the corners
  task automatic set_phase(int k);
    int lo;
    int hi;
    int ease;
    int span;
    lo   = $urandom_range(0, 4095);
    hi   = $urandom_range(0, 4095);
    ease = $urandom_range(1, 64);
    span = $urandom_range(1024, 4095);
    case (k)
      0: begin lo = 0; hi = 4095; end
      1: begin lo = 4095; hi = 0; end
      2: begin ease = 65535; span = 1; end
      3: ease = 0;
      4: span = 0;
      5: hi = lo;
      6: begin ease = 65535; span = 4095; end
      7: begin ease = $urandom_range(1, 4); span = 1; end
      default: ;
    endcase
    settle();
    write_reg(sler_pkg::REG_PULSE_MIN, lo);
    write_reg(sler_pkg::REG_PULSE_MAX, hi);
    write_reg(sler_pkg::REG_EASE_TIME, ease);
    write_reg(sler_pkg::REG_FULL_SPAN, span);
    tx_steady = ($urandom_range(0, 3) == 0);
  endtask

  // Output side: random stalls, with whole stretches of none
  initial begin : rx_side
    int stall;
    int served;
    bit steady;
    served = 0;
    steady = 1'b0;
    forever begin
      if (served % 40 == 0) steady = ($urandom_range(0, 2) == 0);
      stall = steady ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      served++;
    end
  end

  task automatic report_field(string name, int want, int seen);
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
    errors++;
  endtask

  // Compare each output item with the oldest expectation
  always @(posedge clk) begin : check_results
    pulse_report_t seen;
    pulse_report_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      seen.width     = m_tdata[PW-1:0];
      seen.moving    = m_tdata[PW];
      seen.ramp_done = m_tdata[PW+1];
      if (expected_reports.size() == 0) begin
        $display("%0t ns: unexpected item, expected none, got width %0d moving %0b done %0b",
                 $time, seen.width, seen.moving, seen.ramp_done);
        errors++;
      end else begin
        want = expected_reports.pop_front();
        if (seen.width !== want.width) report_field("pulse_width", want.width, seen.width);
        if (seen.moving !== want.moving) report_field("moving", want.moving, seen.moving);
        if (seen.ramp_done !== want.ramp_done)
          report_field("ramp_done", want.ramp_done, seen.ramp_done);
      end
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Bench copy of the reset state
    lim_lo    = sler_pkg::RST_PULSE_MIN;
    lim_hi    = sler_pkg::RST_PULSE_MAX;
    ease_ms   = sler_pkg::RST_EASE_TIME;
    span_us   = sler_pkg::RST_FULL_SPAN;
    pw_now    = int'(sler_pkg::MID_PULSE);
    ramp_from = 0;
    ramp_to   = 0;
    step_no   = 0;
    step_cnt  = 0;
    ramp_on   = 1'b0;

    // Idle tick and a move to where it already is
    add_item(sler_pkg::OP_TICK, 0, 1'b1, 1500, 1'b0, 1'b0);
    add_item(sler_pkg::OP_MOVE, 1500, 1'b1, 1500, 1'b0, 1'b0);
    // Long ramp up; first tick drives the start value
    add_item(sler_pkg::OP_MOVE, 4095, 1'b1, 1500, 1'b1, 1'b0);
    add_item(sler_pkg::OP_TICK, 0, 1'b1, 1500, 1'b1, 1'b0);
    add_item(sler_pkg::OP_TICK, 0);
    // Degree ends, first microsecond value, moves that cut a ramp short
    add_item(sler_pkg::OP_MOVE, 0);
    add_item(sler_pkg::OP_TICK, 0);
    add_item(sler_pkg::OP_MOVE, 199);
    add_item(sler_pkg::OP_MOVE, 200);
    // Short ramp run to its end, then an idle tick
    add_reg(sler_pkg::REG_EASE_TIME, 2);
    add_item(sler_pkg::OP_MOVE, 4095);
    add_item(sler_pkg::OP_TICK, 0);
    add_item(sler_pkg::OP_TICK, 0);
    add_item(sler_pkg::OP_TICK, 0);
    // Zero span and zero ease time: nothing moves
    add_reg(sler_pkg::REG_FULL_SPAN, 0);
    add_item(sler_pkg::OP_MOVE, 300);
    add_item(sler_pkg::OP_TICK, 0);
    add_reg(sler_pkg::REG_FULL_SPAN, 1856);
    add_reg(sler_pkg::REG_EASE_TIME, 0);
    add_item(sler_pkg::OP_MOVE, 1000);
    // Reversed calibration: degree scale clamps to zero, and zero degrees gives the top
    add_reg(sler_pkg::REG_PULSE_MIN, 4095);
    add_reg(sler_pkg::REG_PULSE_MAX, 0);
    add_reg(sler_pkg::REG_EASE_TIME, 3);
    add_reg(sler_pkg::REG_FULL_SPAN, 4095);
    add_item(sler_pkg::OP_MOVE, 199);
    add_item(sler_pkg::OP_MOVE, 0);
    add_item(sler_pkg::OP_TICK, 0);
    add_item(sler_pkg::OP_TICK, 0);
    add_item(sler_pkg::OP_TICK, 0);
    // Full calibration span: top degree saturates
    add_reg(sler_pkg::REG_PULSE_MIN, 0);
    add_reg(sler_pkg::REG_PULSE_MAX, 4095);
    add_item(sler_pkg::OP_MOVE, 199);
    add_item(sler_pkg::OP_TICK, 0);
    add_item(sler_pkg::OP_TICK, 0);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        settle();
        write_reg(plan[i].addr, plan[i].value);
      end else begin
        send_item(plan[i].op, plan[i].value[PW-1:0], plan[i].typed, plan[i].want);
      end
    end

    for (int k = 0; k < PHASES; k++) begin
      set_phase(k);
      repeat (PHASE_ITEMS) random_item();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/sler_pkg.sv
hw/rtl/sler_mul.sv
hw/rtl/sler_div.sv
hw/rtl/servo_linear_ease_ramp_top.sv
bench/tb_top.sv
